/* sv/open_address_hash_set_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the open-address hash set
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_SET_MACROS_SVH
`define OPEN_ADDRESS_HASH_SET_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define OAHS_ASSERT_NOW(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("oahs check failed");

// Next-cycle implication, disabled during reset
`define OAHS_ASSERT_NEXT(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("oahs check failed");

`else

`define OAHS_ASSERT_NOW(label, ck, rstn, ante, cons)
`define OAHS_ASSERT_NEXT(label, ck, rstn, ante, cons)

`endif

`endif

/* sv/oahs_pkg.sv */
// ---------------------------------------------------------------------------
// oahs_pkg
// Sizes, tag and status codes and controller states of the hash set.
// ---------------------------------------------------------------------------
package oahs_pkg;

	localparam int SLOTS      = 1024;
	localparam int KEY_BITS   = 64;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ENTRY_W    = KEY_BITS + 2;
	localparam int FULL_LIMIT = (3 * SLOTS) / 4;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;

	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_TOMB  = 2'd1,
		TAG_LIVE  = 2'd2
	} tag_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_FULL     = 3'd4,
		ST_INVALID  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_DONE
	} state_t;

endpackage

/* sv/oahs_ram.sv */
// ---------------------------------------------------------------------------
// oahs_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module oahs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/open_address_hash_set.sv */
// ---------------------------------------------------------------------------
// open_address_hash_set
// Open-addressing key set with tombstones, add/remove/find per transaction.
// ---------------------------------------------------------------------------
// After reset the block sweeps the slot RAM to empty, one slot per cycle, with
// s_tready low. A request is then taken in the idle state; the probe reads one
// slot per cycle from the single-port-read slot RAM until it stops, and an
// update step then writes the slot and posts the result. A full lap of 1024
// slots that meets neither an empty slot nor the key ends the probe as well,
// and an invalid key or an add refused at the three-quarter load limit skips
// the probe. Probing starts at hash mod 1024 and steps by 8*hash+7; it stops
// at an empty slot or a matching live key and covers at most one full lap.
// The result sits in an output register, so the next request is taken while
// it waits for m_tready; the update step holds until that register is free.
// ---------------------------------------------------------------------------
`include "open_address_hash_set_macros.svh"

module open_address_hash_set (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // cmd[1:0], key[65:2], hash_value[97:66], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata    // status[2:0], match_key[66:3], slot_index[76:67],
	                                // live_entries[87:77]
);

	localparam int IW = oahs_pkg::IDX_W;
	localparam int KW = oahs_pkg::KEY_BITS;

	oahs_pkg::state_t state_q, state_d;

	logic [IW-1:0]             clr_idx_q;
	logic [1:0]                cmd_q;
	logic [KW-1:0]             key_q;
	logic                      skip_q;
	logic [IW-1:0]             cur_q, step_q, start_q;
	logic [oahs_pkg::CNT_W-1:0] cnt_q;
	logic                      rd_vld_s1;
	logic [IW-1:0]             rd_idx_s1;
	logic                      have_tomb_q;
	logic [IW-1:0]             tomb_q;
	logic                      hit_q, avail_q;
	logic [IW-1:0]             res_idx_q;
	logic [oahs_pkg::CNT_W-1:0] live_q;
	logic                      out_vld_q;
	logic [87:0]               out_data_q;

	// input fields
	logic [1:0]    in_cmd;
	logic [KW-1:0] in_key;
	logic [31:0]   in_hash;
	logic          in_bad, in_full, accept;

	assign in_cmd  = s_tdata[1:0];
	assign in_key  = s_tdata[KW+1:2];
	assign in_hash = s_tdata[97:66];
	assign in_bad  = (in_key == '0);
	assign in_full = (in_cmd == oahs_pkg::CMD_ADD) &&
	                 (live_q >= oahs_pkg::CNT_W'(oahs_pkg::FULL_LIMIT));
	assign accept  = s_tvalid && s_tready;

	// slot RAM
	logic                        ram_we, ram_re;
	logic [IW-1:0]               ram_waddr;
	logic [oahs_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

	oahs_ram #(
		.WIDTH(oahs_pkg::ENTRY_W),
		.DEPTH(oahs_pkg::SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cur_q),
		.rdata(ram_rdata)
	);

	// probe check on the slot read last cycle
	oahs_pkg::tag_t rd_tag;
	logic           chk_empty, chk_hit, chk_tomb, stop, lap_end;

	assign rd_tag    = oahs_pkg::tag_t'(ram_rdata[KW+1:KW]);
	assign chk_empty = rd_vld_s1 && (rd_tag == oahs_pkg::TAG_EMPTY);
	assign chk_hit   = rd_vld_s1 && (rd_tag == oahs_pkg::TAG_LIVE) &&
	                   (ram_rdata[KW-1:0] == key_q);
	assign chk_tomb  = rd_vld_s1 && (rd_tag != oahs_pkg::TAG_EMPTY) &&
	                   (rd_tag != oahs_pkg::TAG_LIVE);
	assign stop      = chk_empty || chk_hit;
	assign lap_end   = !rd_vld_s1 && (cnt_q == oahs_pkg::CNT_W'(oahs_pkg::SLOTS));

	logic out_free;
	assign out_free = !out_vld_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oahs_pkg::S_CLEAR: begin
				if (clr_idx_q == IW'(oahs_pkg::SLOTS - 1)) state_d = oahs_pkg::S_IDLE;
			end
			oahs_pkg::S_IDLE: begin
				if (s_tvalid) state_d = (in_bad || in_full) ? oahs_pkg::S_DONE
				                                            : oahs_pkg::S_PROBE;
			end
			oahs_pkg::S_PROBE: begin
				if (stop || lap_end) state_d = oahs_pkg::S_DONE;
			end
			oahs_pkg::S_DONE: begin
				if (out_free) state_d = oahs_pkg::S_IDLE;
			end
			default: state_d = oahs_pkg::S_IDLE;
		endcase
	end

	// outputs of the controller
	oahs_pkg::status_t      status;
	logic [KW-1:0]          mkey;
	logic                   out_load, live_inc, live_dec;

	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = res_idx_q;
		ram_wdata = {oahs_pkg::TAG_EMPTY, {KW{1'b0}}};
		out_load  = 1'b0;
		live_inc  = 1'b0;
		live_dec  = 1'b0;
		status    = oahs_pkg::ST_NOTFOUND;
		mkey      = '0;
		unique case (state_q)
			oahs_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
			end
			oahs_pkg::S_IDLE: begin
				s_tready = 1'b1;
			end
			oahs_pkg::S_PROBE: begin
				ram_re = (cnt_q != oahs_pkg::CNT_W'(oahs_pkg::SLOTS)) && !stop;
			end
			oahs_pkg::S_DONE: begin
				out_load = out_free;
				if (skip_q) begin
					status = (key_q == '0) ? oahs_pkg::ST_INVALID : oahs_pkg::ST_FULL;
				end else if (cmd_q == oahs_pkg::CMD_ADD) begin
					if (hit_q) begin
						status = oahs_pkg::ST_PRESENT;
						mkey   = key_q;
					end else if (avail_q) begin
						status    = oahs_pkg::ST_INSERTED;
						mkey      = key_q;
						ram_we    = out_free;
						ram_wdata = {oahs_pkg::TAG_LIVE, key_q};
						live_inc  = out_free;
					end else begin
						status = oahs_pkg::ST_FULL;
					end
				end else if (cmd_q == oahs_pkg::CMD_REMOVE) begin
					if (hit_q) begin
						status    = oahs_pkg::ST_REMOVED;
						ram_we    = out_free;
						ram_wdata = {oahs_pkg::TAG_TOMB, {KW{1'b0}}};
						live_dec  = out_free && (live_q != '0);
					end
				end else if (hit_q) begin
					status = oahs_pkg::ST_PRESENT;
					mkey   = key_q;
				end
			end
			default: ;
		endcase
	end

	logic [oahs_pkg::CNT_W-1:0] live_next;
	assign live_next = live_inc ? live_q + 1'b1 : (live_dec ? live_q - 1'b1 : live_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= oahs_pkg::S_CLEAR;
			clr_idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			live_q    <= '0;
			out_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			live_q    <= live_next;
			if (state_q == oahs_pkg::S_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
			if (accept) cnt_q <= '0;
			else if (ram_re) cnt_q <= cnt_q + 1'b1;
			if (out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// request and probe payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= in_cmd;
			key_q       <= in_key;
			skip_q      <= in_bad || in_full;
			start_q     <= in_hash[IW-1:0];
			cur_q       <= in_hash[IW-1:0];
			step_q      <= IW'({in_hash, 3'b111});
			have_tomb_q <= 1'b0;
			hit_q       <= 1'b0;
			avail_q     <= 1'b0;
			res_idx_q   <= '0;
		end else if (state_q == oahs_pkg::S_PROBE) begin
			if (ram_re) begin
				cur_q     <= cur_q + step_q;
				rd_idx_s1 <= cur_q;
			end
			// remember the first tombstone on the path
			if (chk_tomb && !have_tomb_q) begin
				have_tomb_q <= 1'b1;
				tomb_q      <= rd_idx_s1;
			end
			if (chk_hit) begin
				hit_q     <= 1'b1;
				res_idx_q <= rd_idx_s1;
			end else if (chk_empty) begin
				avail_q   <= 1'b1;
				res_idx_q <= have_tomb_q ? tomb_q : rd_idx_s1;
			end else if (lap_end) begin
				avail_q   <= have_tomb_q;
				res_idx_q <= have_tomb_q ? tomb_q : start_q;
			end
		end
		if (out_load) begin
			out_data_q <= {11'(live_next), 10'(res_idx_q), 64'(mkey), status};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	`OAHS_ASSERT_NOW(a_live_limit, clk, arst_n, 1'b1, live_q <= oahs_pkg::CNT_W'(oahs_pkg::FULL_LIMIT))
	`OAHS_ASSERT_NOW(a_read_in_probe, clk, arst_n, rd_vld_s1, state_q == oahs_pkg::S_PROBE)
	`OAHS_ASSERT_NEXT(a_result_posted, clk, arst_n, (state_q == oahs_pkg::S_DONE) && out_free, m_tvalid && (state_q == oahs_pkg::S_IDLE))

endmodule

/* test/tb_open_address_hash_set.sv */
// ---------------------------------------------------------------------------
// tb_open_address_hash_set
// Drives add/remove/find requests into the hash set and checks every result
// against a behavioral copy of the slot table: directed corner cases first,
// then colliding and filling random traffic with random stalls on both sides.
// ---------------------------------------------------------------------------
module tb_open_address_hash_set;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_FIND  = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;  // decodes as a find
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 1100;    // longer than a full-lap probe

	typedef struct {
		oahs_pkg::status_t            status;
		logic [63:0]                  match_key;
		logic [oahs_pkg::IDX_W-1:0]   slot;
		logic [oahs_pkg::CNT_W-1:0]   live;
	} outcome_t;

	typedef struct {
		logic [63:0] key;
		logic [31:0] hash;
	} key_entry_t;

	class hash_set_scoreboard;
		oahs_pkg::tag_t                slot_tag[oahs_pkg::SLOTS];
		logic [oahs_pkg::KEY_BITS-1:0] slot_key[oahs_pkg::SLOTS];
		int                            live;
		int                            failures;
		outcome_t                      pending_outcomes[$];

		function new();
			foreach (slot_tag[i]) begin
				slot_tag[i] = oahs_pkg::TAG_EMPTY;
				slot_key[i] = '0;
			end
			live = 0;
			failures = 0;
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction

		// Work out the result of one accepted request and update the table.
		function void record_request(logic [1:0] cmd, logic [63:0] key_in, logic [31:0] hash);
			logic [oahs_pkg::KEY_BITS-1:0] key;
			logic [31:0]                   step_raw;
			int                            start, step, idx, tomb, n;
			bit                            have_tomb, hit, avail, done;
			outcome_t                      res;
			key = key_in[oahs_pkg::KEY_BITS-1:0];
			res.match_key = '0;
			idx = 0;
			if (key == '0) begin
				res.status = oahs_pkg::ST_INVALID;
			end else if (cmd == oahs_pkg::CMD_ADD && 4 * live >= 3 * oahs_pkg::SLOTS) begin
				res.status = oahs_pkg::ST_FULL;
			end else begin
				start = int'(hash & (oahs_pkg::SLOTS - 1));
				step_raw = (hash << 3) + 32'd7;
				step = int'(step_raw & (oahs_pkg::SLOTS - 1));
				idx = start;
				tomb = 0;
				have_tomb = 0;
				hit = 0;
				avail = 0;
				done = 0;
				for (n = 0; n < oahs_pkg::SLOTS && !done; n++) begin
					if (slot_tag[idx] == oahs_pkg::TAG_EMPTY) begin
						avail = 1;
						done = 1;
						if (have_tomb)
							idx = tomb;
					end else if (slot_tag[idx] == oahs_pkg::TAG_LIVE) begin
						if (slot_key[idx] == key) begin
							hit = 1;
							done = 1;
						end
					end else if (!have_tomb) begin
						have_tomb = 1;
						tomb = idx;
					end
					if (!done)
						idx = (idx + step) & (oahs_pkg::SLOTS - 1);
				end
				// full lap without a stop: fall back to the first tombstone, else to the start slot
				if (!done) begin
					if (have_tomb) begin
						avail = 1;
						idx = tomb;
					end else begin
						idx = start;
					end
				end
				if (cmd == oahs_pkg::CMD_ADD) begin
					if (hit) begin
						res.status = oahs_pkg::ST_PRESENT;
						res.match_key = 64'(key);
					end else if (avail) begin
						slot_tag[idx] = oahs_pkg::TAG_LIVE;
						slot_key[idx] = key;
						live++;
						res.status = oahs_pkg::ST_INSERTED;
						res.match_key = 64'(key);
					end else begin
						res.status = oahs_pkg::ST_FULL;
					end
				end else if (cmd == oahs_pkg::CMD_REMOVE) begin
					if (hit) begin
						slot_tag[idx] = oahs_pkg::TAG_TOMB;
						slot_key[idx] = '0;
						if (live > 0)
							live--;
						res.status = oahs_pkg::ST_REMOVED;
					end else begin
						res.status = oahs_pkg::ST_NOTFOUND;
					end
				end else if (hit) begin
					res.status = oahs_pkg::ST_PRESENT;
					res.match_key = 64'(key);
				end else begin
					res.status = oahs_pkg::ST_NOTFOUND;
				end
			end
			res.slot = idx[oahs_pkg::IDX_W-1:0];
			res.live = live[oahs_pkg::CNT_W-1:0];
			pending_outcomes.push_back(res);
		endfunction

		function void check_response(logic [87:0] data);
			logic [2:0]                 got_status;
			logic [63:0]                got_key;
			logic [oahs_pkg::IDX_W-1:0] got_slot;
			logic [oahs_pkg::CNT_W-1:0] got_live;
			outcome_t                   exp;
			got_status = data[2:0];
			got_key    = data[66:3];
			got_slot   = data[76:67];
			got_live   = data[87:77];
			if (pending_outcomes.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] result with no request outstanding: %h", $realtime, data);
				return;
			end
			exp = pending_outcomes.pop_front();
			if (got_status !== exp.status || got_key !== exp.match_key ||
			    got_slot !== exp.slot || got_live !== exp.live) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] mismatch: status %0d/%0d key %h/%h slot %0d/%0d live %0d/%0d",
						$realtime, exp.status, got_status, exp.match_key, got_key,
						exp.slot, got_slot, exp.live, got_live);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;    // cmd[1:0], key[65:2], hash_value[97:66], zero pad
	logic         m_tvalid;
	logic         m_tready;
	logic [87:0]  m_tdata;    // status[2:0], match_key[66:3], slot_index[76:67],
	                          // live_entries[87:77]

	hash_set_scoreboard sb;
	bit                 steady;
	bit                 hold_off_go;
	key_entry_t         hot_keys[$];
	key_entry_t         fresh_keys[$];

	open_address_hash_set dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("** open_address_hash_set: FAILED **");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin : rx_ready
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = steady || ($urandom_range(0, 99) >= 32);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_response(m_tdata);
	end

	// Offer one request; return at a falling edge once the transaction is taken.
	task automatic send_request(logic [1:0] cmd, logic [63:0] key, logic [31:0] hash);
		bit taken;
		while (!steady && $urandom_range(0, 99) < 32) begin
			s_tvalid = 1'b0;
			s_tdata = 104'({$urandom, $urandom, $urandom, $urandom});
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'b0, hash, key, cmd};
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = s_tready;
			if (taken)
				sb.record_request(cmd, key, hash);
			@(negedge clk);
		end
	endtask

	function automatic key_entry_t random_entry();
		key_entry_t e;
		e.key = {$urandom, $urandom};
		e.hash = $urandom;
		return e;
	endfunction

	function automatic key_entry_t pick_fresh();
		return fresh_keys[$urandom_range(0, fresh_keys.size() - 1)];
	endfunction

	initial begin : stimulus
		key_entry_t e;
		logic [63:0] k_ones, k_low, k_top, k_mid;
		int pick;
		sb = new();
		steady = 1'b0;
		hold_off_go = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed corners, starting from an empty table
		k_ones = '1;
		k_low = 64'd1;
		k_top = 64'h8000_0000_0000_0000;
		k_mid = {$urandom, $urandom} | 64'd1;
		send_request(oahs_pkg::CMD_ADD, '0, 32'hFFFF_FFFF);
		send_request(CMD_FIND, '0, 32'h0);
		send_request(oahs_pkg::CMD_REMOVE, '0, 32'h1234_5678);
		send_request(CMD_SPARE, '0, 32'h0);
		send_request(CMD_FIND, k_ones, 32'hFFFF_FFFF);
		send_request(oahs_pkg::CMD_ADD, k_ones, 32'hFFFF_FFFF);
		send_request(oahs_pkg::CMD_ADD, k_ones, 32'hFFFF_FFFF);
		send_request(CMD_FIND, k_ones, 32'hFFFF_FFFF);
		send_request(CMD_SPARE, k_ones, 32'hFFFF_FFFF);
		send_request(oahs_pkg::CMD_ADD, k_low, 32'hFFFF_FFFF);   // same chain as all-ones key
		send_request(oahs_pkg::CMD_ADD, k_top, 32'h0);
		send_request(oahs_pkg::CMD_REMOVE, k_ones, 32'hFFFF_FFFF);
		send_request(CMD_FIND, k_low, 32'hFFFF_FFFF);  // walk past the tombstone
		send_request(oahs_pkg::CMD_REMOVE, k_ones, 32'hFFFF_FFFF);
		send_request(oahs_pkg::CMD_ADD, k_mid, 32'hFFFF_FFFF);   // reuse the tombstone
		send_request(CMD_FIND, k_mid, 32'hFFFF_FFFF);
		send_request(CMD_FIND, k_top, 32'hFFFF_FC00);  // same start and same step as its add
		send_request(oahs_pkg::CMD_REMOVE, k_low, 32'hFFFF_FFFF);
		send_request(oahs_pkg::CMD_REMOVE, k_mid, 32'hFFFF_FFFF);
		send_request(oahs_pkg::CMD_REMOVE, k_top, 32'h0);
		send_request(oahs_pkg::CMD_ADD, k_top, 32'h5555_AAAA);

		// colliding pool: few start slots, so chains and tombstones pile up
		repeat (40) begin
			e = random_entry();
			e.hash[9:0] = 10'($urandom_range(0, 3) * 257);
			hot_keys.push_back(e);
		end
		for (int i = 0; i < 160; i++) begin
			steady = (i >= 60 && i < 140);
			if (i == 70)
				hold_off_go = 1'b1;
			pick = $urandom_range(0, 99);
			e = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
			if (pick < 40)
				send_request(oahs_pkg::CMD_ADD, e.key, e.hash);
			else if (pick < 62)
				send_request(oahs_pkg::CMD_REMOVE, e.key, e.hash);
			else if (pick < 84)
				send_request(CMD_FIND, e.key, e.hash);
			else if (pick < 88)
				send_request(CMD_SPARE, e.key, e.hash);
			else if (pick < 92)
				send_request(2'($urandom_range(0, 3)), '0, $urandom);
			else
				send_request(2'($urandom_range(0, 2)), e.key, $urandom);
		end
		steady = 1'b0;

		// fill up to the load limit with fresh keys
		while (sb.live < oahs_pkg::FULL_LIMIT) begin
			pick = $urandom_range(0, 99);
			if (pick < 94 || fresh_keys.size() == 0) begin
				e = random_entry();
				fresh_keys.push_back(e);
				send_request(oahs_pkg::CMD_ADD, e.key, e.hash);
			end else if (pick < 97) begin
				e = pick_fresh();
				send_request(CMD_FIND, e.key, e.hash);
			end else begin
				e = pick_fresh();
				send_request(oahs_pkg::CMD_REMOVE, e.key, e.hash);
			end
		end

		// churn at the limit: refused adds, removes that open room again
		repeat (40) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				e = random_entry();
				fresh_keys.push_back(e);
				send_request(oahs_pkg::CMD_ADD, e.key, e.hash);
			end else if (pick < 55) begin
				e = pick_fresh();
				send_request(oahs_pkg::CMD_ADD, e.key, e.hash);
			end else if (pick < 75) begin
				e = pick_fresh();
				send_request(oahs_pkg::CMD_REMOVE, e.key, e.hash);
			end else begin
				e = pick_fresh();
				send_request(CMD_FIND, e.key, e.hash);
			end
		end
		s_tvalid = 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("** open_address_hash_set: PASSED **");
		else
			$display("** open_address_hash_set: FAILED **");
		$finish;
	end

endmodule
